// ----- sv/two_way_traffic_light_sequencer_macros.svh -----
// Assertion macros shared by the traffic light sequencer RTL.
`ifndef TWO_WAY_TRAFFIC_LIGHT_SEQUENCER_MACROS_SVH
`define TWO_WAY_TRAFFIC_LIGHT_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
`define TLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLS_ASSERT(lbl, prop, msg)
`define TLS_ASSERT_IMP(lbl, ante, cons, msg)
`define TLS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/tls_pkg.sv -----
// Types, constants and helper functions of the traffic light sequencer.
package tls_pkg;

  localparam int unsigned CntW  = 6;
  localparam int unsigned LampW = 6;
  localparam int unsigned ThrW  = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  localparam logic [CfgIdxW-1:0] CFG_FIRST_START  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_START = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_AMBER_THR    = 2'd2;

  localparam logic [CntW-1:0] FIRST_START_RST  = 6'd35;
  localparam logic [CntW-1:0] SECOND_START_RST = 6'd21;
  localparam logic [ThrW-1:0] AMBER_THR_RST    = 4'd3;

  localparam logic [CntW-1:0] SKIP_HIGH_TOP    = 6'd31;
  localparam logic [CntW-1:0] SKIP_HIGH_BOTTOM = 6'd26;
  localparam logic [CntW-1:0] SKIP_LOW_TOP     = 6'd15;
  localparam logic [CntW-1:0] SKIP_LOW_BOTTOM  = 6'd10;
  localparam logic [CntW-1:0] HANDOVER_START   = 6'd3;

  localparam logic [LampW-1:0] LAMP_OFF      = 6'h00;
  localparam logic [LampW-1:0] LAMP_P1       = 6'h11;
  localparam logic [LampW-1:0] LAMP_P1_AMBER = 6'h21;
  localparam logic [LampW-1:0] LAMP_P2       = 6'h0A;
  localparam logic [LampW-1:0] LAMP_P2_AMBER = 6'h0C;
  localparam logic [LampW-1:0] LAMP_TO1      = 6'h14;
  localparam logic [LampW-1:0] LAMP_TO2      = 6'h22;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_AUTO1 = 3'd1,
    PH_AUTO2 = 3'd2,
    PH_HOLD1 = 3'd3,
    PH_HOLD2 = 3'd4,
    PH_TO1   = 3'd5,
    PH_TO2   = 3'd6
  } tls_phase_e;

  typedef struct packed {
    tls_phase_e       phase;
    logic [CntW-1:0]  counter;
    logic             parity;
    logic             rel_done;
    logic [LampW-1:0] lamp;
    logic [CntW-1:0]  digit;
  } tls_state_t;

  typedef struct packed {
    logic [CntW-1:0] first_start;
    logic [CntW-1:0] second_start;
    logic [ThrW-1:0] amber_thr;
  } tls_cfg_t;

  function automatic tls_state_t tls_manual_top(tls_state_t st, logic sw);
    tls_state_t s;
    s = st;
    if (sw) begin
      s.rel_done = 1'b0;
      if (s.parity) begin
        s.phase   = PH_TO1;
        s.counter = HANDOVER_START;
        s.lamp    = LAMP_TO1;
        s.digit   = HANDOVER_START;
      end else begin
        s.phase = PH_HOLD1;
        s.lamp  = LAMP_P1;
        s.digit = '0;
      end
    end else begin
      s.parity = ~s.parity;
      if (!s.rel_done) begin
        s.phase   = PH_TO2;
        s.counter = HANDOVER_START;
        s.lamp    = LAMP_TO2;
        s.digit   = HANDOVER_START;
      end else begin
        s.phase = PH_HOLD2;
        s.lamp  = LAMP_P2;
        s.digit = '0;
      end
    end
    return s;
  endfunction

endpackage

// ----- sv/tls_in_if.sv -----
// Tick channel carrying the two switch levels.
interface tls_in_if;
  logic valid;
  logic ready;
  logic auto_switch;
  logic manual_switch;

  modport source (output valid, output auto_switch, output manual_switch, input ready);
  modport sink (input valid, input auto_switch, input manual_switch, output ready);
endinterface

// ----- sv/tls_out_if.sv -----
// Result channel carrying the lamp bits and the display digit.
interface tls_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] lamp_bits;
  logic [5:0] display_digit;

  modport source (output valid, output lamp_bits, output display_digit, input ready);
  modport sink (input valid, input lamp_bits, input display_digit, output ready);
endinterface

// ----- sv/tls_next.sv -----
// Next-state logic of the sequencer for one tick.
module tls_next
  import tls_pkg::*;
(
  input  tls_state_t state_i,
  input  tls_cfg_t   cfg_i,
  input  logic       auto_switch_i,
  input  logic       manual_switch_i,
  output tls_state_t state_o
);

  always_comb begin
    tls_state_t s;
    logic done;
    logic amber;
    s     = state_i;
    done  = 1'b0;
    amber = 1'b0;

    if (s.phase == PH_TO1 || s.phase == PH_TO2) begin
      if (s.counter != '0) begin
        s.counter = s.counter - 6'd1;
        s.digit   = s.counter;
        done      = 1'b1;
      end else if (s.phase == PH_TO1) begin
        s.parity = ~s.parity;
        s.phase  = PH_HOLD1;
        s.lamp   = LAMP_P1;
        s.digit  = '0;
      end else begin
        s.rel_done = 1'b1;
        s.phase    = PH_HOLD2;
        s.lamp     = LAMP_P2;
        s.digit    = '0;
      end
    end

    if (!done) begin
      if (auto_switch_i) begin
        if (s.phase != PH_AUTO1 && s.phase != PH_AUTO2) begin
          s.lamp    = LAMP_OFF;
          s.phase   = PH_AUTO1;
          s.counter = cfg_i.first_start;
        end
        if (s.phase == PH_AUTO1 && s.counter <= SKIP_HIGH_TOP
            && s.counter >= SKIP_HIGH_BOTTOM) begin
          s.counter = SKIP_HIGH_BOTTOM - 6'd1;
        end
        if (s.counter <= SKIP_LOW_TOP && s.counter >= SKIP_LOW_BOTTOM) begin
          s.counter = SKIP_LOW_BOTTOM - 6'd1;
        end
        amber = (s.counter <= {2'b00, cfg_i.amber_thr});
        if (s.phase == PH_AUTO1) begin
          s.lamp = amber ? LAMP_P1_AMBER : LAMP_P1;
        end else begin
          s.lamp = amber ? LAMP_P2_AMBER : LAMP_P2;
        end
        s.digit = s.counter;
        if (s.counter == '0) begin
          if (s.phase == PH_AUTO1) begin
            s.phase   = PH_AUTO2;
            s.counter = cfg_i.second_start;
          end else begin
            s.phase   = PH_AUTO1;
            s.counter = cfg_i.first_start;
          end
        end else begin
          s.counter = s.counter - 6'd1;
        end
      end else if (s.phase == PH_HOLD1) begin
        if (!manual_switch_i) begin
          s = tls_manual_top(s, 1'b0);
        end
      end else if (s.phase == PH_HOLD2) begin
        if (manual_switch_i) begin
          s = tls_manual_top(s, 1'b1);
        end
      end else begin
        s.lamp  = LAMP_OFF;
        s.digit = '0;
        s = tls_manual_top(s, manual_switch_i);
      end
    end

    state_o = s;
  end

endmodule

// ----- sv/two_way_traffic_light_sequencer.sv -----
// Top level of the two-way traffic light sequencer.
//
//   Channel  Direction  Payload                        Beat
//   in_ch    sink       auto_switch, manual_switch     one tick
//   out_ch   source     lamp_bits, display_digit       one result per tick
//   cfg      write      cfg_idx_i, cfg_data_i          one register
//
// Each tick beat's result is registered when the beat is accepted and appears the next cycle.
// A new beat is taken every cycle while the result beat is taken or the output is empty.
// The state registers double as the result register, so a stalled output holds in_ch off.
// Reset clears the state and loads the register defaults 35, 21 and 3.
`include "two_way_traffic_light_sequencer_macros.svh"
module two_way_traffic_light_sequencer
  import tls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  tls_in_if.sink              in_ch,
  tls_out_if.source           out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  tls_state_t state_q, state_d;
  tls_cfg_t   cfg_q;
  logic       out_valid_q;
  logic       in_acc;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  tls_next u_next (
    .state_i         (state_q),
    .cfg_i           (cfg_q),
    .auto_switch_i   (in_ch.auto_switch),
    .manual_switch_i (in_ch.manual_switch),
    .state_o         (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_IDLE, counter: '0, parity: 1'b0, rel_done: 1'b0,
                       lamp: '0, digit: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{first_start: FIRST_START_RST, second_start: SECOND_START_RST,
                 amber_thr: AMBER_THR_RST};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST_START:  cfg_q.first_start  <= cfg_data_i;
        CFG_SECOND_START: cfg_q.second_start <= cfg_data_i;
        CFG_AMBER_THR:    cfg_q.amber_thr    <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.lamp_bits     = state_q.lamp;
  assign out_ch.display_digit = state_q.digit;

  `TLS_ASSERT_NXT(a_acc_gives_result, in_acc, out_valid_q, "accepted tick gave no result")
  `TLS_ASSERT_IMP(a_handover_count, (state_q.phase == PH_TO1 || state_q.phase == PH_TO2), (state_q.counter <= HANDOVER_START), "handover count out of range")
  `TLS_ASSERT_IMP(a_hold1_lamps, state_q.phase == PH_HOLD1, (state_q.lamp == LAMP_P1 && state_q.digit == '0), "hold one shows wrong lamps")
  `TLS_ASSERT_IMP(a_hold2_lamps, state_q.phase == PH_HOLD2, (state_q.lamp == LAMP_P2 && state_q.digit == '0), "hold two shows wrong lamps")
  `TLS_ASSERT(a_no_overwrite, (out_valid_q && !out_ch.ready) |=> $stable(state_q), "result changed while stalled")

endmodule
